// File: hw/rtl/jac_pkg.sv
`timescale 1ns / 1ps
package jac_pkg;

    localparam int AXIS_COUNT_DEF = 8;

    // normalization assumes full scale of the form 2^n - 1
    localparam int FS_BITS    = 15;
    localparam int FULL_SCALE = (1 << FS_BITS) - 1;

    // |level| + FULL_SCALE at or above this saturates the magnitude
    localparam logic [33:0] MAG_SAT_LIMIT =
        34'(64'(FULL_SCALE + 1) * 64'(2 * FULL_SCALE));

    localparam int LEVEL_W = 33;
    localparam int VALUE_W = 16;
    localparam int STEP_W  = 15;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [15:0] ALPHA_RST     = 16'd65535;
    localparam logic [14:0] DEAD_ZONE_RST = 15'd3277;
    localparam logic [23:0] RAMP_GAIN_RST = 24'd72818;
    localparam logic [14:0] INIT_STEP_RST = 15'd3277;
    localparam logic [14:0] RUN_STEP_RST  = 15'd33;
    localparam logic [15:0] SWITCH_RST    = 16'd100;
    localparam logic        SLEW_EN_RST   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ALPHA     = 3'd0,
        CFG_DEAD_ZONE        = 3'd1,
        CFG_RAMP_GAIN        = 3'd2,
        CFG_INITIAL_MAX_STEP = 3'd3,
        CFG_RUNNING_MAX_STEP = 3'd4,
        CFG_SWITCH_PERIODS   = 3'd5,
        CFG_SLEW_ENABLE      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0] dead_zone;
        logic [23:0] ramp_gain;
    } t_shape_cfg;

endpackage

// File: hw/rtl/jac_axis_mem.sv
`timescale 1ns / 1ps
module jac_axis_mem #(
    parameter int AXIS_COUNT = jac_pkg::AXIS_COUNT_DEF,
    parameter int AW         = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [AW-1:0]                       i_rd_addr,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [jac_pkg::LEVEL_W-1:0]  i_wr_level,
    input  logic signed [jac_pkg::VALUE_W-1:0]  i_wr_last,
    output logic signed [jac_pkg::LEVEL_W-1:0]  o_rd_level,
    output logic signed [jac_pkg::VALUE_W-1:0]  o_rd_last,
    output logic                                o_rd_seeded
);
    import jac_pkg::*;

    localparam int WORD_W = LEVEL_W + VALUE_W;

    logic [WORD_W-1:0]     r_mem [AXIS_COUNT];
    logic [WORD_W-1:0]     r_rd_word;
    logic [AXIS_COUNT-1:0] r_seeded;
    logic                  r_rd_seeded;

    // axis state words; never-seeded entries are not read for their value
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_level, i_wr_last};
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= '0;
            r_rd_seeded <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_seeded[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_seeded <= r_seeded[i_rd_addr];
            end
        end
    end

    assign o_rd_level  = $signed(r_rd_word[WORD_W-1:VALUE_W]);
    assign o_rd_last   = $signed(r_rd_word[VALUE_W-1:0]);
    assign o_rd_seeded = r_rd_seeded;

endmodule

// File: hw/rtl/jac_shape.sv
`timescale 1ns / 1ps
module jac_shape (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [jac_pkg::LEVEL_W-1:0]  i_level,
    input  jac_pkg::t_shape_cfg                 i_cfg,
    output logic                                o_done,
    output logic signed [jac_pkg::VALUE_W-1:0]  o_desired
);
    import jac_pkg::*;

    logic [3:0] r_vld;

    // stage 1: magnitude, coarse quotient by 2*FULL_SCALE
    logic        w_neg;
    logic [32:0] w_abs;
    logic [33:0] w_x;
    logic [29:0] w_y;
    logic [30:0] w_qsum;
    logic [29:0] r1_y;
    logic [15:0] r1_q0;
    logic        r1_neg;
    logic        r1_sat;

    // stage 2: quotient correction and dead zone
    logic [31:0] w_rem;
    logic [15:0] w_q;
    logic [14:0] w_mag;
    logic [14:0] r2_dmag;
    logic        r2_zero;
    logic        r2_neg;

    // stage 3: gain
    logic [39:0] w_gprod;
    logic [23:0] w_adj_full;
    logic [14:0] r3_adj;
    logic        r3_zero;
    logic        r3_neg;

    // stage 4: square
    logic [30:0] w_sq_full;
    logic [15:0] w_sq;
    logic signed [VALUE_W-1:0] r4_desired;

    always_comb begin
        w_neg  = i_level[LEVEL_W-1];
        w_abs  = w_neg ? 33'(-i_level) : 33'(i_level);
        w_x    = {1'b0, w_abs} + 34'(FULL_SCALE);
        w_y    = w_x[30:1];
        // y / (2^n - 1) ~ (y + y >> n) >> n, short by at most one
        w_qsum = 31'(w_y) + 31'(w_y >> FS_BITS);
    end

    always_comb begin
        w_rem = 32'(r1_y) + 32'(r1_q0) - 32'({r1_q0, 15'd0});
        w_q   = r1_q0 + ((w_rem[16:0] >= 17'(FULL_SCALE)) ? 16'd1 : 16'd0);
        w_mag = r1_sat ? 15'(FULL_SCALE) : w_q[14:0];
    end

    always_comb begin
        w_gprod    = 40'(r2_dmag) * 40'(i_cfg.ramp_gain) + 40'd32768;
        w_adj_full = w_gprod[39:16];
    end

    always_comb begin
        w_sq_full = 31'(30'(r3_adj) * 30'(r3_adj)) + 31'd16384;
        w_sq      = 16'(w_sq_full >> 15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_y   <= w_y;
        r1_q0  <= 16'(w_qsum >> FS_BITS);
        r1_neg <= w_neg;
        r1_sat <= (w_x >= MAG_SAT_LIMIT);

        r2_zero <= (w_mag < i_cfg.dead_zone);
        r2_dmag <= w_mag - i_cfg.dead_zone;
        r2_neg  <= r1_neg;

        r3_adj  <= (w_adj_full > 24'(FULL_SCALE)) ? 15'(FULL_SCALE) : w_adj_full[14:0];
        r3_zero <= r2_zero;
        r3_neg  <= r2_neg;

        if (r3_zero) begin
            r4_desired <= '0;
        end else if (r3_neg) begin
            r4_desired <= -$signed(w_sq);
        end else begin
            r4_desired <= $signed(w_sq);
        end
    end

    assign o_done    = r_vld[3];
    assign o_desired = r4_desired;

endmodule

// File: hw/rtl/joystick_axis_conditioner.sv
`timescale 1ns / 1ps
// An accepted word passes the filter step, the level step and the shaping pipeline,
// then waits until the output register is free; a new word is taken only in idle,
// since the read-filter-write pass over the axis memory and the 4-stage shaping
// pipeline run for one word at a time.
// Reset (synchronous, active low) restores register defaults, clears the period
// count and marks every axis unseeded; no clearing pass over the axis memory.
module joystick_axis_conditioner #(
    parameter int AXIS_COUNT = jac_pkg::AXIS_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [15:0]                    i_s_axis_tdata,  // [15:0] raw_sample
    input  logic [3:0]                     i_s_axis_tuser,  // [2:0] axis_number, [3] period_start
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [15:0]                    o_m_axis_tdata,  // [15:0] conditioned_value
    output logic [2:0]                     o_m_axis_tuser,  // [2:0] result_axis
    input  logic                           i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [jac_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import jac_pkg::*;

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILT  = 5'b00010,
        ST_LEVEL = 5'b00100,
        ST_SHAPE = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_alpha;
    logic [14:0] r_dead_zone;
    logic [23:0] r_ramp_gain;
    logic [14:0] r_init_step;
    logic [14:0] r_run_step;
    logic [15:0] r_switch;
    logic        r_slew_en;
    logic [15:0] r_pcount;

    logic [2:0]                r_axis;
    logic                      r_axis_ok;
    logic signed [15:0]        r_raw;
    logic [STEP_W-1:0]         r_step;
    logic signed [50:0]        r_prod;
    logic signed [LEVEL_W-1:0] r_level;
    logic signed [VALUE_W-1:0] r_value;

    logic                      r_out_valid;
    logic [2:0]                r_out_axis;
    logic signed [VALUE_W-1:0] r_out_value;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic [AW+2:0]             w_in_axis_ext;
    logic [AW+2:0]             w_axis_ext;
    logic                      w_in_axis_ok;
    logic                      w_mem_wr;
    logic signed [LEVEL_W-1:0] w_old_level;
    logic signed [VALUE_W-1:0] w_old_last;
    logic                      w_seeded;
    logic signed [31:0]        w_target;
    logic signed [33:0]        w_diff;
    logic signed [50:0]        w_prod_rnd;
    logic signed [34:0]        w_inc;
    logic signed [LEVEL_W-1:0] n_level;
    logic                      w_shp_done;
    logic signed [VALUE_W-1:0] w_desired;
    logic signed [16:0]        w_sdiff;
    logic signed [16:0]        w_step_s;
    logic signed [16:0]        w_clamped;
    logic signed [VALUE_W-1:0] n_value;
    t_shape_cfg                w_shp_cfg;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_in_axis_ext   = (AW + 3)'(i_s_axis_tuser[2:0]);
    assign w_axis_ext      = (AW + 3)'(r_axis);
    assign w_in_axis_ok    = (6'(i_s_axis_tuser[2:0]) < 6'(AXIS_COUNT));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= ALPHA_RST;
            r_dead_zone <= DEAD_ZONE_RST;
            r_ramp_gain <= RAMP_GAIN_RST;
            r_init_step <= INIT_STEP_RST;
            r_run_step  <= RUN_STEP_RST;
            r_switch    <= SWITCH_RST;
            r_slew_en   <= SLEW_EN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FILTER_ALPHA:     r_alpha     <= i_cfg_wdata[15:0];
                CFG_DEAD_ZONE:        r_dead_zone <= i_cfg_wdata[14:0];
                CFG_RAMP_GAIN:        r_ramp_gain <= i_cfg_wdata[23:0];
                CFG_INITIAL_MAX_STEP: r_init_step <= i_cfg_wdata[14:0];
                CFG_RUNNING_MAX_STEP: r_run_step  <= i_cfg_wdata[14:0];
                CFG_SWITCH_PERIODS:   r_switch    <= i_cfg_wdata[15:0];
                CFG_SLEW_ENABLE:      r_slew_en   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_shp_cfg.dead_zone = r_dead_zone;
    assign w_shp_cfg.ramp_gain = r_ramp_gain;

    jac_axis_mem #(
        .AXIS_COUNT (AXIS_COUNT),
        .AW         (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_in_acc && w_in_axis_ok),
        .i_rd_addr   (w_in_axis_ext[AW-1:0]),
        .i_wr_en     (w_mem_wr),
        .i_wr_addr   (w_axis_ext[AW-1:0]),
        .i_wr_level  (r_level),
        .i_wr_last   (n_value),
        .o_rd_level  (w_old_level),
        .o_rd_last   (w_old_last),
        .o_rd_seeded (w_seeded)
    );

    // filter arithmetic
    always_comb begin
        w_target   = $signed({r_raw, 16'd0});
        w_diff     = 34'(w_target) - 34'(w_old_level);
        w_prod_rnd = r_prod + 51'sd32768;
        w_inc      = 35'(w_prod_rnd >>> 16);
        if (w_seeded) begin
            n_level = LEVEL_W'(35'(w_old_level) + w_inc);
        end else begin
            n_level = LEVEL_W'(w_target);
        end
    end

    jac_shape u_shape (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_LEVEL),
        .i_level   (n_level),
        .i_cfg     (w_shp_cfg),
        .o_done    (w_shp_done),
        .o_desired (w_desired)
    );

    // slew limit against the last output of the axis
    always_comb begin
        w_step_s = $signed({2'b00, r_step});
        w_sdiff  = 17'(w_desired) - 17'(w_old_last);
        if (w_sdiff > w_step_s) begin
            w_clamped = w_step_s;
        end else if (w_sdiff < -w_step_s) begin
            w_clamped = -w_step_s;
        end else begin
            w_clamped = w_sdiff;
        end
        if (!r_axis_ok) begin
            n_value = '0;
        end else if (!w_seeded || !r_slew_en) begin
            n_value = w_desired;
        end else begin
            n_value = VALUE_W'(17'(w_old_last) + w_clamped);
        end
    end

    assign w_mem_wr = (r_state == ST_SHAPE) && w_shp_done && r_axis_ok;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_FILT;
            ST_FILT:  n_state = ST_LEVEL;
            ST_LEVEL: n_state = ST_SHAPE;
            ST_SHAPE: if (w_shp_done) n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_s_axis_tuser[3] && (r_pcount != 16'hFFFF)) begin
                r_pcount <= r_pcount + 16'd1;
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_axis    <= i_s_axis_tuser[2:0];
            r_axis_ok <= w_in_axis_ok;
            r_raw     <= $signed(i_s_axis_tdata);
            r_step    <= (r_pcount < r_switch) ? r_init_step : r_run_step;
        end
        if (r_state == ST_FILT) begin
            r_prod <= 51'($signed({1'b0, r_alpha}) * w_diff);
        end
        if (r_state == ST_LEVEL) begin
            r_level <= n_level;
        end
        if (r_state == ST_SHAPE && w_shp_done) begin
            r_value <= n_value;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out_axis  <= r_axis;
            r_out_value <= r_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_axis;

    a_accept_to_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_FILT))
        else $error("accepted word did not start the filter step");

    a_shape_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shp_done |-> (r_state == ST_SHAPE))
        else $error("shaping result arrived outside the wait state");

    a_pcount_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> (r_pcount == $past(r_pcount)))
        else $error("period count moved while no word was accepted");

    a_unused_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !r_axis_ok) |-> (r_value == '0 && !w_mem_wr))
        else $error("unused axis produced a value or a state write");

endmodule

// File: tb/sv/tb_joystick_axis_conditioner.sv
`timescale 1ns / 1ps
module tb_joystick_axis_conditioner;
    import jac_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_WORDS  = 135;
    localparam int SWITCH_WORDS = 100;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [2:0]         axis;
        logic signed [15:0] raw;
        logic               period_start;
    } t_axis_word;

    typedef struct packed {
        logic [2:0]  axis;
        logic [15:0] level;
    } t_cond_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic [15:0] s_data = '0;
    logic [3:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    always #2 i_clk = ~i_clk;

    joystick_axis_conditioner u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),   // [15:0] raw_sample
        .i_s_axis_tuser  (s_user),   // [2:0] axis_number, [3] period_start
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [15:0] conditioned_value
        .o_m_axis_tuser  (o_m_axis_tuser),  // [2:0] result_axis
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // conditioner model state and register copy
    longint alpha_q16    = ALPHA_RST;
    longint dead_zone_q15 = DEAD_ZONE_RST;
    longint gain_q16     = RAMP_GAIN_RST;
    longint init_step    = INIT_STEP_RST;
    longint run_step     = RUN_STEP_RST;
    longint switch_count = SWITCH_RST;
    longint slew_on      = SLEW_EN_RST;
    longint filt_level [AXIS_COUNT_DEF];
    longint prev_output [AXIS_COUNT_DEF];
    bit     seeded [AXIS_COUNT_DEF];
    longint period_count = 0;

    t_axis_word pending_words[$];
    t_cond_word expected_words[$];
    t_axis_word cur_word;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int checked_count = 0;

    // normalize, dead zone, remap, square, restore sign
    function automatic longint shape_level(longint level);
        longint mag, adj, sq;
        bit neg;
        neg = level < 0;
        mag = ((neg ? -level : level) + FULL_SCALE) / (2 * FULL_SCALE);
        if (mag > 32767) mag = 32767;
        if (mag < dead_zone_q15) return 0;
        adj = ((mag - dead_zone_q15) * gain_q16 + 32768) >>> 16;
        if (adj > 32767) adj = 32767;
        sq = (adj * adj + 16384) >>> 15;
        return neg ? -sq : sq;
    endfunction

    function automatic t_cond_word condition_word(t_axis_word w);
        longint max_step, target, desired, diff, outv;
        t_cond_word res;
        max_step = (period_count < switch_count) ? init_step : run_step;
        if (w.period_start && period_count < 65535) period_count++;
        target = longint'(w.raw) * 65536;
        if (!seeded[w.axis]) begin
            filt_level[w.axis] = target;
            outv = shape_level(target);
            seeded[w.axis] = 1'b1;
        end else begin
            filt_level[w.axis] += (alpha_q16 * (target - filt_level[w.axis]) + 32768) >>> 16;
            desired = shape_level(filt_level[w.axis]);
            if (slew_on != 0) begin
                diff = desired - prev_output[w.axis];
                if (diff > max_step) diff = max_step;
                else if (diff < -max_step) diff = -max_step;
                outv = prev_output[w.axis] + diff;
            end else begin
                outv = desired;
            end
        end
        prev_output[w.axis] = outv;
        res.axis = w.axis;
        res.level = outv[15:0];
        return res;
    endfunction

    // source side: advance when the current word is taken or none is held
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready)
                expected_words.push_back(condition_word(cur_word));
            if (!s_valid || o_s_axis_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_data <= cur_word.raw;
                    s_user <= {cur_word.period_start, cur_word.axis};
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: check each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        t_cond_word exp_w;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                checked_count++;
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected word: axis %0d value %0d",
                                 o_m_axis_tuser, $signed(o_m_axis_tdata));
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.axis !== o_m_axis_tuser || exp_w.level !== o_m_axis_tdata) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"word %0d: expected axis %0d value %0d, ",
                                      "got axis %0d value %0d"},
                                     checked_count, exp_w.axis, $signed(exp_w.level),
                                     o_m_axis_tuser, $signed(o_m_axis_tdata));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(t_cfg_idx idx, longint val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        case (idx)
            CFG_FILTER_ALPHA:     alpha_q16 = val & 16'hFFFF;
            CFG_DEAD_ZONE:        dead_zone_q15 = val & 15'h7FFF;
            CFG_RAMP_GAIN:        gain_q16 = val & 24'hFFFFFF;
            CFG_INITIAL_MAX_STEP: init_step = val & 15'h7FFF;
            CFG_RUNNING_MAX_STEP: run_step = val & 15'h7FFF;
            CFG_SWITCH_PERIODS:   switch_count = val & 16'hFFFF;
            CFG_SLEW_ENABLE:      slew_on = val & 1;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(int axis, int raw, bit ps);
        t_axis_word w;
        w.axis = axis[2:0];
        w.raw = raw[15:0];
        w.period_start = ps;
        pending_words.push_back(w);
    endtask

    // realistic stick readings, full-range noise and hard stops
    task automatic push_random_word(bit ps);
        int raw;
        case ($urandom_range(9))
            0, 1, 2, 3: raw = int'($signed(16'($urandom)));
            4, 5, 6: raw = $urandom_range(0, 8000);
            7: raw = -$urandom_range(0, 8000);
            8: raw = $urandom_range(0, 1) ? 32767 : -32767;
            default: raw = -32768;
        endcase
        if ($urandom_range(1) && raw > -32768) raw = $urandom_range(1) ? raw : -raw;
        push_word($urandom_range(0, 7), raw, ps);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || s_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase_config(int ph);
        case (ph)
            0: ;
            1: begin
                write_reg(CFG_FILTER_ALPHA, 0);
                write_reg(CFG_DEAD_ZONE, 0);
                write_reg(CFG_RAMP_GAIN, 65536);
                write_reg(CFG_INITIAL_MAX_STEP, 32767);
                write_reg(CFG_RUNNING_MAX_STEP, 0);
                write_reg(CFG_SWITCH_PERIODS, period_count + 10);
                write_reg(CFG_SLEW_ENABLE, 1);
            end
            2: begin
                write_reg(CFG_FILTER_ALPHA, 65535);
                write_reg(CFG_DEAD_ZONE, 32767);
                write_reg(CFG_RAMP_GAIN, 24'hFFFFFF);
                write_reg(CFG_INITIAL_MAX_STEP, 0);
                write_reg(CFG_RUNNING_MAX_STEP, 32767);
                write_reg(CFG_SWITCH_PERIODS, 0);
                write_reg(CFG_SLEW_ENABLE, 0);
            end
            default: begin
                write_reg(CFG_FILTER_ALPHA, $urandom_range(0, 65535));
                write_reg(CFG_DEAD_ZONE, (ph == 5) ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 6000));
                // one phase lets the gain drop below one
                write_reg(CFG_RAMP_GAIN, (ph == 3) ? $urandom_range(0, 24'hFFFFFF)
                                                   : $urandom_range(65536, 400000));
                write_reg(CFG_INITIAL_MAX_STEP, $urandom_range(0, 32767));
                write_reg(CFG_RUNNING_MAX_STEP, $urandom_range(0, 2000));
                write_reg(CFG_SWITCH_PERIODS, period_count + $urandom_range(0, 30));
                write_reg(CFG_SLEW_ENABLE, (ph == 4) ? 0 : 1);
            end
        endcase
    endtask

    initial begin
        for (int a = 0; a < AXIS_COUNT_DEF; a++) begin
            filt_level[a] = 0;
            prev_output[a] = 0;
            seeded[a] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first samples seed each axis, then hard reversals hit the slew clamp
        push_word(0, 32767, 1);
        push_word(1, -32768, 0);
        push_word(2, 0, 1);
        push_word(3, -32767, 0);
        push_word(4, 3000, 0);
        push_word(5, 3277, 1);
        push_word(6, 3278, 0);
        push_word(7, -3277, 0);
        push_word(0, -32768, 1);
        push_word(1, 32767, 0);
        push_word(0, -32768, 0);
        push_word(2, 32767, 1);
        push_word(2, 32767, 0);
        push_word(4, -32768, 0);
        push_word(5, 1, 1);
        push_word(6, -1, 0);
        push_word(7, 16384, 0);
        push_word(3, 32767, 1);
        push_word(4, 2000, 0);
        push_word(1, -32768, 0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            set_phase_config(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
                push_random_word($urandom_range(3) == 0);
        end

        // mark every word as a new period so the count crosses the start-up switch
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_FILTER_ALPHA, $urandom_range(1000, 65535));
        write_reg(CFG_DEAD_ZONE, 0);
        write_reg(CFG_RAMP_GAIN, 65536);
        write_reg(CFG_INITIAL_MAX_STEP, 32767);
        write_reg(CFG_RUNNING_MAX_STEP, 5);
        write_reg(CFG_SWITCH_PERIODS, period_count + 40);
        write_reg(CFG_SLEW_ENABLE, 1);
        for (int n = 0; n < SWITCH_WORDS; n++)
            push_random_word(1'b1);

        wait_idle();
        mismatch_count += expected_words.size();
        $display("Checked %0d conditioned words over %0d phases plus a start-up switch run;",
                 checked_count, NUM_PHASES);
        $display("register extremes, slew on and off, period count ended at %0d.",
                 period_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out waiting for conditioned words");
        $display("Mismatches found");
        $finish;
    end

endmodule
